// ===== src/ddid_pkg.sv =====
// Package for the date difference block: widths, codes, controller types
// and the calendar helper functions. No dependencies.
package ddid_pkg;

    localparam int YEAR_W     = 14;
    localparam int MONTH_W    = 4;
    localparam int DAY_W      = 5;
    localparam int COUNT_W    = 22;
    localparam int DOY_W      = 9;
    localparam int ACC_W      = 24;
    localparam int BCD_DIGITS = 5;
    localparam int BCD_W      = 4 * BCD_DIGITS;
    localparam int BITCNT_W   = 4;

    localparam logic [MONTH_W-1:0] MONTH_JAN   = MONTH_W'(1);
    localparam logic [MONTH_W-1:0] MONTH_FEB   = MONTH_W'(2);
    localparam logic [MONTH_W-1:0] MONTH_DEC   = MONTH_W'(12);
    localparam logic [DOY_W-1:0]   DAYS_COMMON = DOY_W'(365);
    localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_START,
        S_YEAR,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic conv;
        logic start_lo;
        logic step_year;
        logic add_hi;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic bad;
        logic conv_done;
        logic at_hi;
    } t_dp_status;

    // Days before the first of the month in a common year.
    function automatic logic [DOY_W-1:0] month_start(input logic [MONTH_W-1:0] m);
        logic [DOY_W-1:0] r;
        unique case (m)
            4'd1:    r = DOY_W'(0);
            4'd2:    r = DOY_W'(31);
            4'd3:    r = DOY_W'(59);
            4'd4:    r = DOY_W'(90);
            4'd5:    r = DOY_W'(120);
            4'd6:    r = DOY_W'(151);
            4'd7:    r = DOY_W'(181);
            4'd8:    r = DOY_W'(212);
            4'd9:    r = DOY_W'(243);
            4'd10:   r = DOY_W'(273);
            4'd11:   r = DOY_W'(304);
            4'd12:   r = DOY_W'(334);
            default: r = DOY_W'(0);
        endcase
        return r;
    endfunction

    // Leap rule from the two low binary bits and the decimal digits of the year.
    // A century year is a leap year when its hundreds value is a multiple of four;
    // since 10 is 2 mod 4 and 100 is 0 mod 4, only two digits matter for that.
    function automatic logic is_leap(input logic [1:0] y_low,
                                     input logic [BCD_W-1:0] bcd);
        logic       century;
        logic [1:0] hund_mod4;
        century   = (bcd[7:0] == 8'd0);
        hund_mod4 = bcd[9:8] + {bcd[12], 1'b0};
        return century ? (hund_mod4 == 2'd0) : (y_low == 2'd0);
    endfunction

    function automatic logic [DOY_W-1:0] day_of_year(input logic [MONTH_W-1:0] m,
                                                     input logic [DAY_W-1:0]   d,
                                                     input logic               leap);
        logic extra;
        extra = (m > MONTH_FEB) && leap;
        return month_start(m) + DOY_W'(d) + {{(DOY_W-1){1'b0}}, extra};
    endfunction

    function automatic logic [BCD_W-1:0] bcd_inc(input logic [BCD_W-1:0] v);
        logic [BCD_W-1:0] r;
        logic             c;
        r = v;
        c = 1'b1;
        for (int k = 0; k < BCD_DIGITS; k++) begin
            if (c) begin
                if (r[4*k +: 4] == 4'd9) begin
                    r[4*k +: 4] = 4'd0;
                end else begin
                    r[4*k +: 4] = r[4*k +: 4] + 4'd1;
                    c = 1'b0;
                end
            end
        end
        return r;
    endfunction

    // One shift-and-add-3 step of binary to decimal conversion.
    function automatic logic [BCD_W-1:0] bcd_dabble(input logic [BCD_W-1:0] v,
                                                    input logic             b);
        logic [BCD_W-1:0] r;
        r = v;
        for (int k = 0; k < BCD_DIGITS; k++) begin
            if (r[4*k +: 4] >= 4'd5) begin
                r[4*k +: 4] = r[4*k +: 4] + 4'd3;
            end
        end
        return {r[BCD_W-2:0], b};
    endfunction

endpackage

// ===== src/ddid_dp.sv =====
// Datapath of the date difference block: operand registers, year walker,
// decimal year counter, day accumulator and result register. Uses ddid_pkg.
module ddid_dp import ddid_pkg::*; (
    input  logic               i_clk,
    input  t_dp_cmd            i_cmd,
    input  logic [YEAR_W-1:0]  i_first_year,
    input  logic [MONTH_W-1:0] i_first_month,
    input  logic [DAY_W-1:0]   i_first_day,
    input  logic [YEAR_W-1:0]  i_second_year,
    input  logic [MONTH_W-1:0] i_second_month,
    input  logic [DAY_W-1:0]   i_second_day,
    output t_dp_status         o_status,
    output logic [COUNT_W-1:0] o_day_count,
    output logic               o_bad_month
);

    logic [YEAR_W-1:0]   r_y_hi;
    logic [MONTH_W-1:0]  r_m_lo, r_m_hi;
    logic [DAY_W-1:0]    r_d_lo, r_d_hi;
    logic                r_bad;
    logic [YEAR_W-1:0]   r_year;
    logic [YEAR_W-1:0]   r_shift;
    logic [BCD_W-1:0]    r_bcd;
    logic [BITCNT_W-1:0] r_bit_cnt;
    logic [ACC_W-1:0]    r_acc;
    logic [COUNT_W-1:0]  r_count;
    logic                r_bad_out;

    logic                swap;
    logic                bad_in;
    logic                leap_now;
    logic [DOY_W-1:0]    doy_lo, doy_hi, year_len;
    logic [ACC_W-1:0]    mag;
    logic [COUNT_W-1:0]  sat;

    always_comb begin
        swap     = i_first_year > i_second_year;
        bad_in   = (i_first_month < MONTH_JAN) || (i_first_month > MONTH_DEC) ||
                   (i_second_month < MONTH_JAN) || (i_second_month > MONTH_DEC);
        leap_now = is_leap(r_year[1:0], r_bcd);
        doy_lo   = day_of_year(r_m_lo, r_d_lo, leap_now);
        doy_hi   = day_of_year(r_m_hi, r_d_hi, leap_now);
        year_len = DAYS_COMMON + {{(DOY_W-1){1'b0}}, leap_now};
        mag      = r_acc[ACC_W-1] ? (ACC_W'(0) - r_acc) : r_acc;
        sat      = (mag > ACC_W'(COUNT_MAX)) ? COUNT_MAX : mag[COUNT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_y_hi    <= swap ? i_first_year   : i_second_year;
            r_m_hi    <= swap ? i_first_month  : i_second_month;
            r_d_hi    <= swap ? i_first_day    : i_second_day;
            r_m_lo    <= swap ? i_second_month : i_first_month;
            r_d_lo    <= swap ? i_second_day   : i_first_day;
            r_year    <= swap ? i_second_year  : i_first_year;
            r_shift   <= swap ? i_second_year  : i_first_year;
            r_bad     <= bad_in;
            r_bcd     <= '0;
            r_bit_cnt <= '0;
        end
        if (i_cmd.conv) begin
            r_bcd     <= bcd_dabble(r_bcd, r_shift[YEAR_W-1]);
            r_shift   <= {r_shift[YEAR_W-2:0], 1'b0};
            r_bit_cnt <= r_bit_cnt + BITCNT_W'(1);
        end
        if (i_cmd.start_lo) begin
            r_acc <= ACC_W'(0) - ACC_W'(doy_lo);
        end
        if (i_cmd.step_year) begin
            r_acc  <= r_acc + ACC_W'(year_len);
            r_year <= r_year + YEAR_W'(1);
            r_bcd  <= bcd_inc(r_bcd);
        end
        if (i_cmd.add_hi) begin
            r_acc <= r_acc + ACC_W'(doy_hi);
        end
        if (i_cmd.out_load) begin
            r_count   <= r_bad ? '0 : sat;
            r_bad_out <= r_bad;
        end
    end

    assign o_status.bad       = r_bad;
    assign o_status.conv_done = (r_bit_cnt == BITCNT_W'(YEAR_W));
    assign o_status.at_hi     = (r_year == r_y_hi);
    assign o_day_count        = r_count;
    assign o_bad_month        = r_bad_out;

endmodule

// ===== src/ddid_ctrl.sv =====
// Controller of the date difference block: sequences the datapath and owns
// the input ready and output valid handshakes. Uses ddid_pkg.
module ddid_ctrl import ddid_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CONV;
                end
            end
            S_CONV: begin
                if (i_status.bad) begin
                    n_state = S_DONE;
                end else if (i_status.conv_done) begin
                    n_state = S_START;
                end else begin
                    o_cmd.conv = 1'b1;
                end
            end
            S_START: begin
                o_cmd.start_lo = 1'b1;
                n_state        = S_YEAR;
            end
            S_YEAR: begin
                if (i_status.at_hi) begin
                    o_cmd.add_hi = 1'b1;
                    n_state      = S_DONE;
                end else begin
                    o_cmd.step_year = 1'b1;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== src/date_difference_in_days.sv =====
// Top level of the Gregorian date difference block.
// Instantiates ddid_ctrl and ddid_dp; uses ddid_pkg.
//
// This block takes two Gregorian dates per input beat and returns one output
// beat holding the absolute number of days between them, saturated to the
// 22-bit range. The earlier-year date is chosen first, its year is converted
// to decimal digits (one bit per cycle) so the century rules can be checked,
// and then the block walks forward one year per clock cycle, adding 365 or
// 366 days, until it reaches the later year; the year walk is the part of an
// item's time that grows with the year span. A month outside 1 to 12 in
// either date sets o_bad_month with a zero count and skips the conversion
// and the year walk. Days are not checked against the length of their
// month. The result sits in an output register, so a new input beat can be
// taken while the last result waits.
module date_difference_in_days import ddid_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [YEAR_W-1:0]  i_first_year,
    input  logic [MONTH_W-1:0] i_first_month,
    input  logic [DAY_W-1:0]   i_first_day,
    input  logic [YEAR_W-1:0]  i_second_year,
    input  logic [MONTH_W-1:0] i_second_month,
    input  logic [DAY_W-1:0]   i_second_day,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [COUNT_W-1:0] o_day_count,
    output logic               o_bad_month
);

    t_dp_cmd    cmd;
    t_dp_status status;

    ddid_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    ddid_dp u_dp (
        .i_clk          (i_clk),
        .i_cmd          (cmd),
        .i_first_year   (i_first_year),
        .i_first_month  (i_first_month),
        .i_first_day    (i_first_day),
        .i_second_year  (i_second_year),
        .i_second_month (i_second_month),
        .i_second_day   (i_second_day),
        .o_status       (status),
        .o_day_count    (o_day_count),
        .o_bad_month    (o_bad_month)
    );

`ifndef SYNTHESIS
    // A bad-month result always carries a zero count.
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_bad_month |-> o_day_count == '0)
        else $error("bad month result with nonzero count");

    // The result register is never overwritten while a result still waits.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!o_out_valid || i_out_ready))
        else $error("result register overwritten before its beat was taken");

    // After an input beat is taken, input ready is low in the cycle after.
    a_busy_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input ready right after an accepted beat");

    // At most one datapath command is issued in any cycle.
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.load, cmd.conv, cmd.start_lo, cmd.step_year, cmd.add_hi,
                  cmd.out_load}))
        else $error("more than one datapath command in a cycle");
`endif

endmodule

// ===== dv/date_difference_in_days_tb.sv =====
// Self-checking testbench for date_difference_in_days: drives date pairs over
// the input channel and compares every output beat with its own calendar model.
// Depends on ddid_pkg and the date_difference_in_days RTL only.
`timescale 1ns / 1ps

module date_difference_in_days_tb;
    import ddid_pkg::*;

    // The limit allows nearly four times the length of a run in which every
    // item walked the widest year span, with both sides stalling as long as
    // they may.
    localparam int unsigned LIMIT_CYCLES = 6_500_000;
    localparam int unsigned YEAR_TOP     = (1 << YEAR_W) - 1;
    // Once the last expected beat has been taken, this many more cycles are
    // watched for a beat that should never come.
    localparam int unsigned SETTLE_CYCLES = 100;

    typedef struct packed {
        logic [COUNT_W-1:0] days;
        logic               bad;
    } t_gap;

    logic               i_clk          = 1'b0;
    logic               i_rst_n        = 1'b0;
    logic               i_in_valid     = 1'b0;
    logic               o_in_ready;
    logic [YEAR_W-1:0]  i_first_year   = '0;
    logic [MONTH_W-1:0] i_first_month  = '0;
    logic [DAY_W-1:0]   i_first_day    = '0;
    logic [YEAR_W-1:0]  i_second_year  = '0;
    logic [MONTH_W-1:0] i_second_month = '0;
    logic [DAY_W-1:0]   i_second_day   = '0;
    logic               o_out_valid;
    logic               i_out_ready    = 1'b0;
    logic [COUNT_W-1:0] o_day_count;
    logic               o_bad_month;

    // Day counts still owed by the block, oldest first.
    t_gap        expected_gaps[$];
    int unsigned mismatches  = 0;
    int unsigned cycle_count = 0;
    int unsigned ready_hold  = 0;
    // While calm is set neither side inserts idle cycles.
    bit          calm        = 1'b0;

    date_difference_in_days u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_first_year   (i_first_year),
        .i_first_month  (i_first_month),
        .i_first_day    (i_first_day),
        .i_second_year  (i_second_year),
        .i_second_month (i_second_month),
        .i_second_day   (i_second_day),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_day_count    (o_day_count),
        .o_bad_month    (o_bad_month)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Calendar model
    // ------------------------------------------------------------------

    function automatic bit leap_year(input int unsigned y);
        return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
    endfunction

    // Days in the months before month m of a common year.
    function automatic int unsigned days_before_month(input logic [MONTH_W-1:0] m);
        case (m)
            4'd2:    return 31;
            4'd3:    return 59;
            4'd4:    return 90;
            4'd5:    return 120;
            4'd6:    return 151;
            4'd7:    return 181;
            4'd8:    return 212;
            4'd9:    return 243;
            4'd10:   return 273;
            4'd11:   return 304;
            4'd12:   return 334;
            default: return 0;
        endcase
    endfunction

    // Day number counted from the start of year zero of the proleptic
    // calendar. The day of month goes in unchecked, zero and overruns too.
    function automatic int unsigned day_number(input logic [YEAR_W-1:0]  y,
                                               input logic [MONTH_W-1:0] m,
                                               input logic [DAY_W-1:0]   d);
        int unsigned yy;
        int unsigned n;
        yy = 32'(y);
        n  = 365 * yy + (yy + 3) / 4 - (yy + 99) / 100 + (yy + 399) / 400;
        n  = n + days_before_month(m) + 32'(d);
        if (m > MONTH_FEB && leap_year(yy)) begin
            n = n + 1;
        end
        return n;
    endfunction

    function automatic t_gap predict_gap(input logic [YEAR_W-1:0]  y_a,
                                         input logic [MONTH_W-1:0] m_a,
                                         input logic [DAY_W-1:0]   d_a,
                                         input logic [YEAR_W-1:0]  y_b,
                                         input logic [MONTH_W-1:0] m_b,
                                         input logic [DAY_W-1:0]   d_b);
        t_gap        r;
        int unsigned n_a;
        int unsigned n_b;
        int unsigned span;
        if (m_a < MONTH_JAN || m_a > MONTH_DEC || m_b < MONTH_JAN || m_b > MONTH_DEC) begin
            r.days = '0;
            r.bad  = 1'b1;
            return r;
        end
        n_a  = day_number(y_a, m_a, d_a);
        n_b  = day_number(y_b, m_b, d_b);
        span = (n_a > n_b) ? n_a - n_b : n_b - n_a;
        // Spans past the 22-bit count clamp at the top value.
        if (span > 32'(COUNT_MAX)) begin
            span = 32'(COUNT_MAX);
        end
        r.days = span[COUNT_W-1:0];
        r.bad  = 1'b0;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Channel handling
    // ------------------------------------------------------------------

    function automatic int unsigned draw_wait();
        return calm ? 0 : $urandom_range(0, 9);
    endfunction

    // Sends one date pair. On return the beat has just been taken at this
    // edge and valid is still high, so the caller must either send again or
    // drop valid through drain_results.
    task automatic send_dates(input logic [YEAR_W-1:0]  y_a,
                              input logic [MONTH_W-1:0] m_a,
                              input logic [DAY_W-1:0]   d_a,
                              input logic [YEAR_W-1:0]  y_b,
                              input logic [MONTH_W-1:0] m_b,
                              input logic [DAY_W-1:0]   d_b);
        int unsigned gap;
        gap = draw_wait();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_first_year   <= y_a;
        i_first_month  <= m_a;
        i_first_day    <= d_a;
        i_second_year  <= y_b;
        i_second_month <= m_b;
        i_second_day   <= d_b;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        expected_gaps.push_back(predict_gap(y_a, m_a, d_a, y_b, m_b, d_b));
    endtask

    // Holds the input side off until every owed beat has come back.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (expected_gaps.size() != 0) @(posedge i_clk);
    endtask

    // Output side: compares each beat taken with the oldest owed count and
    // then draws how long to hold ready low before the next one.
    always @(posedge i_clk) begin
        t_gap want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_gaps.size() == 0) begin
                $display("%0t: unexpected beat, day_count %0d bad_month %b",
                         $time, o_day_count, o_bad_month);
                mismatches++;
            end else begin
                want = expected_gaps.pop_front();
                if (o_day_count !== want.days) begin
                    $display("%0t: day_count mismatch, expected %0d actual %0d",
                             $time, want.days, o_day_count);
                    mismatches++;
                end
                if (o_bad_month !== want.bad) begin
                    $display("%0t: bad_month mismatch, expected %b actual %b",
                             $time, want.bad, o_bad_month);
                    mismatches++;
                end
            end
            ready_hold = draw_wait();
        end
        if (ready_hold > 0) begin
            ready_hold--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Identical dates, the widest legal span in both orders, a span that
    // overflows the count and days that lie outside their month.
    task automatic test_extreme_dates();
        send_dates(14'd2024, 4'd6, 5'd15, 14'd2024, 4'd6, 5'd15);
        send_dates(14'd1, 4'd1, 5'd1, 14'd9999, 4'd12, 5'd31);
        send_dates(14'd9999, 4'd12, 5'd31, 14'd1, 4'd1, 5'd1);
        send_dates(YEAR_TOP[YEAR_W-1:0], 4'd12, 5'd31, 14'd0, 4'd1, 5'd0);
        send_dates(14'd2023, 4'd2, 5'd31, 14'd2023, 4'd3, 5'd0);
        drain_results();
    endtask

    // The leap rule: a year divisible by 400, a plain century, an ordinary
    // leap year, year zero and a century boundary between two years.
    task automatic test_leap_rules();
        send_dates(14'd2000, 4'd2, 5'd28, 14'd2000, 4'd3, 5'd1);
        send_dates(14'd1900, 4'd2, 5'd28, 14'd1900, 4'd3, 5'd1);
        send_dates(14'd2024, 4'd12, 5'd31, 14'd2024, 4'd1, 5'd1);
        send_dates(14'd0, 4'd3, 5'd1, 14'd0, 4'd2, 5'd29);
        send_dates(14'd2100, 4'd3, 5'd1, 14'd2099, 4'd12, 5'd31);
        drain_results();
    endtask

    // A month out of range on either side, or both, gives a zero count.
    task automatic test_bad_months();
        send_dates(14'd2020, 4'd0, 5'd1, 14'd2021, 4'd5, 5'd1);
        send_dates(14'd2020, 4'd13, 5'd10, 14'd2020, 4'd1, 5'd10);
        send_dates(14'd0, 4'd7, 5'd4, YEAR_TOP[YEAR_W-1:0], 4'd14, 5'd31);
        send_dates(14'd1999, 4'd12, 5'd31, 14'd1, 4'd15, 5'd0);
        send_dates(YEAR_TOP[YEAR_W-1:0], 4'd0, 5'd31, 14'd0, 4'd15, 5'd1);
        drain_results();
    endtask

    // Every month on both sides, across a leap year and a common one.
    task automatic test_every_month();
        for (int m = 1; m <= 12; m++) begin
            send_dates(14'd2024, m[MONTH_W-1:0], 5'd1,
                       14'd2025, 4'(13 - m), 5'(m + 17));
        end
        drain_results();
    endtask

    // Mostly valid pairs at most two hundred years apart, some with the second
    // year drawn from the whole year range and some with a bad month. The first
    // stretch runs without idle cycles on either side, as does a later one.
    task automatic test_random_dates(input int unsigned count);
        logic [YEAR_W-1:0]  y_a;
        logic [YEAR_W-1:0]  y_b;
        logic [MONTH_W-1:0] m_a;
        logic [MONTH_W-1:0] m_b;
        int                 y_near;
        int unsigned        pick;
        int unsigned        bad_code;
        for (int unsigned i = 0; i < count; i++) begin
            calm = (i < 20) || (i >= 60 && i < 70);
            pick = $urandom_range(0, 99);
            y_a  = YEAR_W'($urandom_range(0, YEAR_TOP));
            m_a  = MONTH_W'($urandom_range(1, 12));
            m_b  = MONTH_W'($urandom_range(1, 12));
            if (pick < 4) begin
                y_b = YEAR_W'($urandom_range(0, YEAR_TOP));
            end else begin
                y_near = int'(y_a) + int'($urandom_range(0, 400)) - 200;
                if (y_near < 0) begin
                    y_near = 0;
                end else if (y_near > int'(YEAR_TOP)) begin
                    y_near = int'(YEAR_TOP);
                end
                y_b = y_near[YEAR_W-1:0];
            end
            if (pick >= 90) begin
                // Out-of-range months are 0 and 13 to 15.
                bad_code = $urandom_range(0, 3);
                if (bad_code == 0) begin
                    bad_code = 0;
                end else begin
                    bad_code = 12 + bad_code;
                end
                if (pick[0]) begin
                    m_a = bad_code[MONTH_W-1:0];
                end else begin
                    m_b = bad_code[MONTH_W-1:0];
                end
            end
            send_dates(y_a, m_a, 5'($urandom_range(0, 31)),
                       y_b, m_b, 5'($urandom_range(0, 31)));
        end
        calm = 1'b0;
        drain_results();
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_extreme_dates();
        test_leap_rules();
        test_bad_months();
        test_every_month();
        test_random_dates(73);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
